>>> rtl/core/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg: shared types and constants of the palette color selector
// Item kinds, color modes, register indexes and the remainder unit's
// request and response bundles.
// ----------------------------------------------------------------------------
package pcs_pkg;

  localparam int COLOR_W = 16;
  localparam int CNT_W   = 11;  // color_count and block_size width
  localparam int DVD_W   = 20;  // remainder unit dividend width

  localparam logic [COLOR_W-1:0] FORCED_INDEX = 16'hFFFF;
  localparam logic [COLOR_W-1:0] ALPHA_BIT    = 16'h8000;

  localparam logic [2:0] KIND_LOAD  = 3'd0;
  localparam logic [2:0] KIND_GET   = 3'd1;
  localparam logic [2:0] KIND_STEP  = 3'd2;
  localparam logic [2:0] KIND_TRY   = 3'd3;
  localparam logic [2:0] KIND_RESET = 3'd4;

  localparam logic [1:0] MODE_PALETTE = 2'd0;
  localparam logic [1:0] MODE_RGB     = 2'd1;
  localparam logic [1:0] MODE_AUTO    = 2'd2;
  localparam logic [1:0] MODE_NONE    = 2'd3;

  localparam logic [1:0] REG_COLOR_MODE  = 2'd0;
  localparam logic [1:0] REG_COLOR_COUNT = 2'd1;
  localparam logic [1:0] REG_BLOCK_SIZE  = 2'd2;

  typedef struct packed {
    logic             go;
    logic [DVD_W-1:0] dvd;
    logic [CNT_W-1:0] dvs;
  } mod_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [CNT_W-1:0] rem;
  } mod_rsp_t;

  // 0xRRGGBB to 1:5:5:5 with alpha set
  function automatic logic [COLOR_W-1:0] rgb24_to_16(input logic [23:0] rgb);
    return ALPHA_BIT | {1'b0, rgb[23:19], rgb[15:11], rgb[7:3]};
  endfunction

endpackage

>>> rtl/core/pcs_mod_unit.sv
// ----------------------------------------------------------------------------
// pcs_mod_unit: iterative remainder unit
// Restoring division, one dividend bit per cycle; returns the remainder.
// ----------------------------------------------------------------------------
module pcs_mod_unit
  import pcs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mod_req_t req_i,
  output mod_rsp_t rsp_o
);

  localparam int CW = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [CNT_W-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [CNT_W:0]   trial;

  assign trial = {rem_q, dvd_q[DVD_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (busy_q) begin
      // subtract when the partial remainder covers the divisor
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = CNT_W'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = CNT_W'(trial);
      end
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.go) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DVD_W);
      dvd_d  = req_i.dvd;
      dvs_d  = req_i.dvs;
      rem_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

>>> rtl/core/palette_color_selector.sv
// ----------------------------------------------------------------------------
// palette_color_selector: palette memory with color selection slots
// Loads palette entries, returns slot colors, steps and searches slot
// indices under a small sequencer sharing one remainder unit.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                     Contents
// s_axis    in   s_axis_tvalid/tready          request: kind, slot, load data,
//                                              step, try color
// m_axis    out  m_axis_tvalid/tready          color, index, ok
// cfg       in   cfg_valid_i/cfg_ready_o       register index and data
//
// Work: a step item makes one remainder pass; a palette try-set makes up to
// two (block alignment, then color count) and then reads and compares one
// palette entry at a time (one memory read port, registered read data),
// up to 2047 entries. Load, get and other items need no remainder pass.
// Reset: asynchronous active low; clears control, modes, slots; the palette
// memory is not cleared. One request is worked on at a time; the input is
// not ready until the previous result sits in the output register, which
// holds while m_axis_tready is low.
// ----------------------------------------------------------------------------
module palette_color_selector
  import pcs_pkg::*;
#(
  parameter int PALETTE_DEPTH = 1024,
  parameter int SLOT_COUNT    = 2,
  parameter int FIRST_START   = 0,
  parameter int SECOND_START  = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [9:0] entry_address, [33:10] entry_rgb, [41:34] step, [57:42] try_color
  input  logic [63:0] s_axis_tdata,
  // [2:0] kind, [3] slot
  input  logic [3:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] color_out, [31:16] index_out, [32] ok
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i
);

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_EXEC  = 4'd1;
  localparam logic [3:0] ST_STEPM = 4'd2;
  localparam logic [3:0] ST_STEPW = 4'd3;
  localparam logic [3:0] ST_ALIGN = 4'd4;
  localparam logic [3:0] ST_EMOD  = 4'd5;
  localparam logic [3:0] ST_RD    = 4'd6;
  localparam logic [3:0] ST_CMP   = 4'd7;
  localparam logic [3:0] ST_GETW  = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;

  function automatic logic [COLOR_W-1:0] place_idx(input int i);
    return COLOR_W'(FIRST_START + i * (SECOND_START - FIRST_START));
  endfunction

  // configuration
  logic [1:0]       mode_q;
  logic [CNT_W-1:0] cc_q, bs_q;

  // request held for the whole item
  logic [2:0]  kind_q;
  logic        slot_q;
  logic [9:0]  addr_q;
  logic [23:0] rgb_q;
  logic [7:0]  step_q;
  logic [15:0] tc_q;

  // slots
  logic [COLOR_W-1:0] idx_q [SLOT_COUNT];
  logic [COLOR_W-1:0] idx_d [SLOT_COUNT];
  logic [COLOR_W-1:0] fcol_q [SLOT_COUNT];
  logic [COLOR_W-1:0] fcol_d [SLOT_COUNT];
  logic [4:0]         red_q [SLOT_COUNT];
  logic [4:0]         red_d [SLOT_COUNT];
  logic [4:0]         grn_q [SLOT_COUNT];
  logic [4:0]         grn_d [SLOT_COUNT];
  logic [4:0]         blu_q [SLOT_COUNT];
  logic [4:0]         blu_d [SLOT_COUNT];

  // sequencer
  logic [3:0]         state_q, state_d;
  logic signed [20:0] v_q, v_d;
  logic [CNT_W-1:0]   e_q, e_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [COLOR_W-1:0] res_color_q, res_color_d;
  logic               res_ok_q, res_ok_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [39:0] out_data_q, out_data_d;
  logic        out_free;

  // memory
  logic [COLOR_W-1:0] mem [PALETTE_DEPTH];
  logic [COLOR_W-1:0] rdata_q;
  logic [AW-1:0]      raddr;
  logic               mem_we;

  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  logic               in_acc;
  logic               slot_ok;
  logic [SW-1:0]      sel;
  logic [COLOR_W-1:0] idx_sel;
  logic signed [19:0] prod;
  logic               e_in_mem;
  logic [CNT_W-1:0]   e_next;
  logic [COLOR_W-1:0] start_al;
  logic [CNT_W-1:0]   step_m;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign slot_ok  = (32'(slot_q) < SLOT_COUNT);
  assign sel      = SW'(slot_q);
  assign idx_sel  = slot_ok ? idx_q[sel] : '0;
  assign prod     = $signed(step_q) * $signed({1'b0, bs_q});
  assign e_in_mem = (32'(e_q) < PALETTE_DEPTH);
  assign e_next   = (e_q + CNT_W'(1) == cc_q) ? '0 : e_q + CNT_W'(1);
  assign start_al = idx_sel - COLOR_W'(mod_rsp.rem);
  // negative sums fold back from the top of the range
  assign step_m   = v_q[20] ? cc_q - CNT_W'(1) - mod_rsp.rem : mod_rsp.rem;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PALETTE;
      cc_q   <= CNT_W'(576);
      bs_q   <= CNT_W'(64);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_COLOR_MODE:  mode_q <= cfg_data_i[1:0];
        REG_COLOR_COUNT: cc_q   <= cfg_data_i;
        REG_BLOCK_SIZE:  bs_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // capture the request
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= s_axis_tuser[2:0];
      slot_q <= s_axis_tuser[3];
      addr_q <= s_axis_tdata[9:0];
      rgb_q  <= s_axis_tdata[33:10];
      step_q <= s_axis_tdata[41:34];
      tc_q   <= s_axis_tdata[57:42];
    end
  end

  // palette memory: one write port, one registered read port
  assign mem_we = (state_q == ST_EXEC) && (kind_q == KIND_LOAD) &&
                  (32'(addr_q) < PALETTE_DEPTH);
  assign raddr  = (state_q == ST_EXEC) ? AW'(idx_sel) : AW'(e_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[AW'(addr_q)] <= rgb24_to_16(rgb_q);
    end
    rdata_q <= mem[raddr];
  end

  pcs_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    v_d         = v_q;
    e_d         = e_q;
    cnt_d       = cnt_q;
    res_color_d = res_color_q;
    res_ok_d    = res_ok_q;
    idx_d       = idx_q;
    fcol_d      = fcol_q;
    red_d       = red_q;
    grn_d       = grn_q;
    blu_d       = blu_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    mod_req     = '0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d     = ST_EXEC;
          res_color_d = '0;
          res_ok_d    = 1'b0;
        end
      end
      ST_EXEC: begin
        state_d = ST_FIN;
        if (kind_q == KIND_LOAD) begin
          res_ok_d = mem_we;
        end else if (kind_q == KIND_RESET) begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            idx_d[i] = place_idx(i);
          end
          res_ok_d = 1'b1;
        end else if (!slot_ok) begin
          // invalid slot: nothing to do
        end else begin
          case (kind_q)
            KIND_GET: begin
              case (mode_q)
                MODE_PALETTE: begin
                  res_ok_d = 1'b1;
                  if ((32'(idx_sel) < 32'(cc_q)) && (32'(idx_sel) < PALETTE_DEPTH)) begin
                    state_d = ST_GETW;
                  end else begin
                    res_color_d = fcol_q[sel];
                  end
                end
                MODE_RGB: begin
                  res_color_d = ALPHA_BIT |
                                {1'b0, red_q[sel], grn_q[sel], blu_q[sel]};
                  res_ok_d    = 1'b1;
                end
                MODE_AUTO: begin
                  res_color_d = fcol_q[sel];
                  res_ok_d    = 1'b1;
                end
                default: ;
              endcase
            end
            KIND_STEP: begin
              if (cc_q != '0) begin
                v_d     = $signed({5'b0, idx_sel}) + 21'(prod);
                state_d = ST_STEPM;
              end
            end
            KIND_TRY: begin
              case (mode_q)
                MODE_PALETTE: begin
                  res_ok_d = 1'b1;
                  if (bs_q != '0) begin
                    mod_req.go  = 1'b1;
                    mod_req.dvd = DVD_W'(idx_sel);
                    mod_req.dvs = bs_q;
                    state_d     = ST_ALIGN;
                  end else if (cc_q != '0) begin
                    mod_req.go  = 1'b1;
                    mod_req.dvd = DVD_W'(idx_sel);
                    mod_req.dvs = cc_q;
                    state_d     = ST_EMOD;
                  end else begin
                    fcol_d[sel] = tc_q;
                    idx_d[sel]  = FORCED_INDEX;
                  end
                end
                MODE_RGB: begin
                  red_d[sel] = tc_q[14:10];
                  grn_d[sel] = tc_q[9:5];
                  blu_d[sel] = tc_q[4:0];
                  res_ok_d   = 1'b1;
                end
                MODE_AUTO: begin
                  fcol_d[sel] = tc_q;
                  res_ok_d    = 1'b1;
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end
      ST_STEPM: begin
        // remainder of |v|, or of -v-1 for a negative sum
        mod_req.go  = 1'b1;
        mod_req.dvd = v_q[20] ? ~v_q[DVD_W-1:0] : v_q[DVD_W-1:0];
        mod_req.dvs = cc_q;
        state_d     = ST_STEPW;
      end
      ST_STEPW: begin
        if (mod_rsp.done) begin
          idx_d[sel] = COLOR_W'(step_m);
          res_ok_d   = 1'b1;
          state_d    = ST_FIN;
        end
      end
      ST_ALIGN: begin
        if (mod_rsp.done) begin
          if (cc_q != '0) begin
            mod_req.go  = 1'b1;
            mod_req.dvd = DVD_W'(start_al);
            mod_req.dvs = cc_q;
            state_d     = ST_EMOD;
          end else begin
            fcol_d[sel] = tc_q;
            idx_d[sel]  = FORCED_INDEX;
            state_d     = ST_FIN;
          end
        end
      end
      ST_EMOD: begin
        if (mod_rsp.done) begin
          e_d     = mod_rsp.rem;
          cnt_d   = cc_q;
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (e_in_mem && (rdata_q == tc_q)) begin
          idx_d[sel] = COLOR_W'(e_q);
          state_d    = ST_FIN;
        end else if (cnt_q == CNT_W'(1)) begin
          fcol_d[sel] = tc_q;
          idx_d[sel]  = FORCED_INDEX;
          state_d     = ST_FIN;
        end else begin
          cnt_d   = cnt_q - CNT_W'(1);
          e_d     = e_next;
          state_d = ST_RD;
        end
      end
      ST_GETW: begin
        res_color_d = rdata_q;
        state_d     = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {7'b0, res_ok_q, idx_sel, res_color_q};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        idx_q[i]  <= place_idx(i);
        fcol_q[i] <= '0;
        red_q[i]  <= '0;
        grn_q[i]  <= '0;
        blu_q[i]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      fcol_q      <= fcol_d;
      red_q       <= red_d;
      grn_q       <= grn_d;
      blu_q       <= blu_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q         <= v_d;
    e_q         <= e_d;
    cnt_q       <= cnt_d;
    res_color_q <= res_color_d;
    res_ok_q    <= res_ok_d;
    out_data_q  <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result raised outside the finish step");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_rsp.done |-> (state_q == ST_STEPW || state_q == ST_ALIGN ||
                      state_q == ST_EMOD))
    else $error("remainder done with no waiting step");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> (e_q < cc_q && cnt_q != '0))
    else $error("palette scan index out of range");

  a_go_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_req.go |-> !mod_rsp.busy)
    else $error("remainder unit started while busy");
`endif

endmodule

>>> dv/tb_palette_color_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_palette_color_selector: self-checking bench for the palette color selector
// Fills the low palette entries, walks a table of directed requests and then
// runs random phases under several register settings. Every result is checked
// against an in-bench predictor or a typed row; both streams stall at random.
// ----------------------------------------------------------------------------
module tb_palette_color_selector;
  import pcs_pkg::*;

  localparam int DEPTH      = 1024;
  localparam int FILL       = 256;
  localparam int NSLOT      = 2;
  localparam int SPACING    = 64;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [2:0] KIND_BAD5 = 3'd5;
  localparam logic [2:0] KIND_BAD7 = 3'd7;

  typedef struct packed {
    logic [15:0] color;
    logic [15:0] index;
    logic        ok;
  } color_rsp_t;

  typedef struct {
    logic [2:0]  kind;
    logic        slot;
    logic [9:0]  addr;
    logic [23:0] rgb;
    logic [7:0]  step;
    logic [15:0] tc;
    bit          typed;
    color_rsp_t  rsp;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [3:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [10:0] cfg_data_i = '0;

  // Shadow state of the selector
  logic [1:0]  sh_mode;
  int unsigned sh_count, sh_block;
  logic [15:0] sh_palette [DEPTH];
  logic [15:0] sh_index [NSLOT];
  logic [15:0] sh_forced [NSLOT];
  logic [4:0]  sh_red [NSLOT], sh_green [NSLOT], sh_blue [NSLOT];

  color_rsp_t  pending_colors[$];
  int          fail_count = 0;
  int          idle_cycles = 0;
  bit          stall_on = 1'b1;
  int          src_gap = 0;
  int          sink_gap = 0;
  dir_row_t    dir_tab[19];

  palette_color_selector dut (.*);

  always #6 clk_i = ~clk_i;

  // Place the slots as a reset request does
  function automatic void place_slots();
    for (int i = 0; i < NSLOT; i++) sh_index[i] = 16'(i * SPACING);
  endfunction

  // Apply one request to the shadow state and return its result
  function automatic color_rsp_t predict_color(logic [2:0] kind, logic slot,
      logic [9:0] addr, logic [23:0] rgb, logic [7:0] step, logic [15:0] tc);
    color_rsp_t r;
    longint     v, m;
    int unsigned start, e;
    bit         hit;
    r = '0;
    case (kind)
      KIND_LOAD: begin
        sh_palette[addr] = ALPHA_BIT | {1'b0, rgb[23:19], rgb[15:11], rgb[7:3]};
        r.ok = 1'b1;
      end
      KIND_RESET: begin
        place_slots();
        r.ok = 1'b1;
      end
      KIND_GET: begin
        r.ok = (sh_mode != MODE_NONE);
        case (sh_mode)
          MODE_PALETTE: r.color = (sh_index[slot] < sh_count && sh_index[slot] < DEPTH) ?
                                  sh_palette[sh_index[slot]] : sh_forced[slot];
          MODE_RGB:     r.color = ALPHA_BIT | {1'b0, sh_red[slot], sh_green[slot],
                                               sh_blue[slot]};
          MODE_AUTO:    r.color = sh_forced[slot];
          default:      r.color = '0;
        endcase
      end
      KIND_STEP: begin
        if (sh_count != 0) begin
          v = longint'(sh_index[slot]) + longint'($signed(step)) * longint'(sh_block);
          m = v % longint'(sh_count);
          if (m < 0) m += sh_count;
          sh_index[slot] = 16'(m);
          r.ok = 1'b1;
        end
      end
      KIND_TRY: begin
        r.ok = (sh_mode != MODE_NONE);
        if (sh_mode == MODE_PALETTE) begin
          start = sh_index[slot];
          hit = 1'b0;
          if (sh_block > 0) start -= start % sh_block;
          for (int unsigned i = 0; i < sh_count && !hit; i++) begin
            e = (i + start) % sh_count;
            if (e < DEPTH && sh_palette[e] == tc) begin
              sh_index[slot] = 16'(e);
              hit = 1'b1;
            end
          end
          if (!hit) begin
            sh_forced[slot] = tc;
            sh_index[slot] = FORCED_INDEX;
          end
        end else if (sh_mode == MODE_RGB) begin
          sh_red[slot]   = tc[14:10];
          sh_green[slot] = tc[9:5];
          sh_blue[slot]  = tc[4:0];
        end else if (sh_mode == MODE_AUTO) begin
          sh_forced[slot] = tc;
        end
      end
      default: ;
    endcase
    r.index = sh_index[slot];
    return r;
  endfunction

  // Drive one request, hold it until taken, then queue its expected result
  task automatic send_request(logic [2:0] kind, logic slot, logic [9:0] addr,
      logic [23:0] rgb, logic [7:0] step, logic [15:0] tc,
      bit typed = 1'b0, color_rsp_t typed_rsp = '0);
    color_rsp_t r;
    if (stall_on && src_gap == 0 && $urandom_range(0, 7) == 0)
      src_gap = $urandom_range(1, 18);
    if (src_gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (src_gap) @(posedge clk_i);
      src_gap = 0;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {slot, kind};
    s_axis_tdata  <= {6'b0, tc, step, rgb, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    r = predict_color(kind, slot, addr, rgb, step, tc);
    pending_colors.push_back(typed ? typed_rsp : r);
  endtask

  // Drop valid and wait until every result is back
  task automatic drain();
    @(posedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_COLOR_MODE:  sh_mode  = val[1:0];
      REG_COLOR_COUNT: sh_count = val;
      default:         sh_block = val;
    endcase
  endtask

  task automatic random_request();
    int          pick;
    logic [2:0]  kind;
    logic [15:0] tc;
    pick = $urandom_range(0, 99);
    if (pick < 20)      kind = KIND_LOAD;
    else if (pick < 45) kind = KIND_GET;
    else if (pick < 65) kind = KIND_STEP;
    else if (pick < 90) kind = KIND_TRY;
    else if (pick < 95) kind = KIND_RESET;
    else                kind = 3'($urandom_range(KIND_BAD5, KIND_BAD7));
    // Offer a color that sits in the filled palette about half the time
    if ($urandom_range(0, 1))
      tc = sh_palette[$urandom_range(0,
             ((sh_count > 0 && sh_count < FILL) ? sh_count : FILL) - 1)];
    else
      tc = 16'($urandom);
    send_request(kind, 1'($urandom), 10'($urandom), 24'($urandom), 8'($urandom), tc);
  endtask

  // Result side: random stall bursts, check against the oldest expectation
  always @(posedge clk_i) begin
    color_rsp_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[32]};
      if (pending_colors.size() == 0) begin
        $error("unexpected result %h", got);
        fail_count++;
      end else begin
        want = pending_colors.pop_front();
        if (got.color !== want.color) begin
          $error("color_out: expected %h, got %h", want.color, got.color);
          fail_count++;
        end
        if (got.index !== want.index) begin
          $error("index_out: expected %h, got %h", want.index, got.index);
          fail_count++;
        end
        if (got.ok !== want.ok) begin
          $error("ok: expected %b, got %b", want.ok, got.ok);
          fail_count++;
        end
      end
    end
    if (sink_gap > 0) begin
      sink_gap--;
    end else if (stall_on && $urandom_range(0, 7) == 0) begin
      sink_gap = $urandom_range(1, 18);
    end
    m_axis_tready <= rst_ni && (sink_gap == 0);
  end

  // Watchdog: count cycles with no handshake on any channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [1:0]  mode;
    logic [10:0] count, blk;
    dir_tab[0]  = '{KIND_RESET, 0, 0, 0, 0, 0, 1, '{16'h0, 16'd0, 1'b1}};
    dir_tab[1]  = '{KIND_RESET, 1, 0, 0, 0, 0, 1, '{16'h0, 16'd64, 1'b1}};
    dir_tab[2]  = '{KIND_LOAD, 0, 10'd0, 24'hFFFFFF, 0, 0, 1, '{16'h0, 16'd0, 1'b1}};
    dir_tab[3]  = '{KIND_LOAD, 1, 10'd1023, 24'h000000, 0, 0, 1,
                    '{16'h0, 16'd64, 1'b1}};
    dir_tab[4]  = '{KIND_GET, 0, 0, 0, 0, 0, 1, '{16'hFFFF, 16'd0, 1'b1}};
    dir_tab[5]  = '{KIND_GET, 1, 0, 0, 0, 0, 0, '0};
    dir_tab[6]  = '{KIND_STEP, 0, 0, 0, 8'd1, 0, 1, '{16'h0, 16'd64, 1'b1}};
    dir_tab[7]  = '{KIND_STEP, 0, 0, 0, 8'h7F, 0, 0, '0};
    dir_tab[8]  = '{KIND_STEP, 0, 0, 0, 8'h80, 0, 0, '0};
    // Loaded entries all carry alpha, so a color without it always misses
    dir_tab[9]  = '{KIND_TRY, 0, 0, 0, 0, 16'h0000, 1, '{16'h0, FORCED_INDEX, 1'b1}};
    dir_tab[10] = '{KIND_GET, 0, 0, 0, 0, 0, 1, '{16'h0, FORCED_INDEX, 1'b1}};
    dir_tab[11] = '{KIND_TRY, 1, 0, 0, 0, 16'hFFFF, 0, '0};
    dir_tab[12] = '{KIND_TRY, 0, 0, 0, 0, 16'h7FFF, 1, '{16'h0, FORCED_INDEX, 1'b1}};
    dir_tab[13] = '{KIND_GET, 0, 0, 0, 0, 0, 1, '{16'h7FFF, FORCED_INDEX, 1'b1}};
    dir_tab[14] = '{KIND_STEP, 0, 0, 0, 8'd1, 0, 0, '0};
    dir_tab[15] = '{KIND_TRY, 1, 0, 0, 0, 16'h8000, 0, '0};
    dir_tab[16] = '{KIND_BAD7, 1, 10'h3FF, 24'hFFFFFF, 8'hFF, 16'hFFFF, 0, '0};
    dir_tab[17] = '{KIND_BAD5, 0, 0, 0, 0, 0, 0, '0};
    dir_tab[18] = '{KIND_RESET, 0, 0, 0, 0, 0, 1, '{16'h0, 16'd0, 1'b1}};

    sh_mode = MODE_PALETTE;
    sh_count = 576;
    sh_block = 64;
    for (int i = 0; i < NSLOT; i++) begin
      sh_forced[i] = '0;
      sh_red[i] = '0;
      sh_green[i] = '0;
      sh_blue[i] = '0;
    end
    place_slots();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the low palette; palette-mode counts never reach past it, so no
    // search or get ever reads an unwritten entry
    for (int a = 0; a < FILL; a++)
      send_request(KIND_LOAD, 1'($urandom), 10'(a), 24'($urandom), 8'($urandom),
                   16'($urandom));
    drain();
    write_reg(REG_COLOR_COUNT, 11'(FILL));

    // Directed table, reset register values apart from the color count
    foreach (dir_tab[i])
      send_request(dir_tab[i].kind, dir_tab[i].slot, dir_tab[i].addr, dir_tab[i].rgb,
                   dir_tab[i].step, dir_tab[i].tc, dir_tab[i].typed, dir_tab[i].rsp);

    // Random phases; the early ones pin the register extremes
    for (int ph = 0; ph < 10; ph++) begin
      drain();
      case (ph)
        0: begin mode = MODE_PALETTE; count = 11'd1;    blk = 11'd0;    end
        1: begin mode = MODE_PALETTE; count = 11'(FILL); blk = 11'd1024; end
        2: begin mode = MODE_RGB;     count = 11'd1024; blk = 11'd1;    end
        3: begin mode = MODE_AUTO;    count = 11'd300;  blk = 11'd0;    end
        4: begin mode = MODE_NONE;    count = 11'd1;    blk = 11'd1024; end
        default: begin
          mode  = 2'($urandom);
          count = (mode == MODE_PALETTE) ? 11'($urandom_range(1, FILL)) :
                                           11'($urandom_range(1, 1024));
          blk   = 11'($urandom_range(0, 1024));
        end
      endcase
      write_reg(REG_COLOR_MODE, 11'(mode));
      write_reg(REG_COLOR_COUNT, count);
      write_reg(REG_BLOCK_SIZE, blk);
      // Run the last phase without stalls
      if (ph == 9) stall_on = 1'b0;
      repeat (30) random_request();
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
